// ----- design/exps_pkg.sv -----
// exps_pkg: widths, register indexes, reset values and state codes of the
// ring exclusion-process block; no dependencies
`timescale 1ns / 1ps

package exps_pkg;

  // configuration registers
  localparam int unsigned CFG_IDX_W        = 2;
  localparam int unsigned CFG_DATA_W       = 17;
  localparam int unsigned SITE_COUNT_W     = 11;
  localparam int unsigned PARTICLE_COUNT_W = 10;
  localparam int unsigned RIGHT_PROB_W     = 17;

  localparam logic [CFG_IDX_W-1:0] REG_SITE_COUNT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PARTICLE_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_PROB     = 2'd2;

  localparam logic [SITE_COUNT_W-1:0]     SITE_COUNT_RST     = 11'd1024;
  localparam logic [PARTICLE_COUNT_W-1:0] PARTICLE_COUNT_RST = 10'd512;
  localparam logic [RIGHT_PROB_W-1:0]     RIGHT_PROB_RST     = 17'd32768;

  // beat fields
  localparam int unsigned KIND_W     = 1;
  localparam int unsigned PARTICLE_W = 10;
  localparam int unsigned FRACTION_W = 16;
  localparam int unsigned POSITION_W = 10;
  localparam int unsigned DISP_W     = 24;
  localparam int unsigned DSUM_W     = 34;
  localparam int unsigned SQSUM_W    = 56;

  localparam logic [KIND_W-1:0] KIND_MOVE = 1'b0;
  localparam logic [KIND_W-1:0] KIND_INIT = 1'b1;

  localparam logic signed [DISP_W-1:0] DISP_LIMIT     = 24'sd8388607;
  localparam logic signed [DISP_W-1:0] DISP_LIMIT_NEG = -24'sd8388607;

  // size defaults
  localparam int unsigned DEF_MAX_SITES     = 1024;
  localparam int unsigned DEF_MAX_PARTICLES = 1023;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SWEEP,
    ST_TAIL_RD,
    ST_TAIL_WR,
    ST_MV_A,
    ST_MV_B,
    ST_EMIT
  } exps_state_e;

endpackage

// ----- design/exps_if.sv -----
// exps_in_if / exps_out_if: valid-ready channels for move items and results
// depends on exps_pkg
`timescale 1ns / 1ps

interface exps_in_if import exps_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [KIND_W-1:0]     kind;
  logic [PARTICLE_W-1:0] particle;
  logic [FRACTION_W-1:0] random_fraction;

  modport source (output valid, kind, particle, random_fraction, input ready);
  modport sink (input valid, kind, particle, random_fraction, output ready);
endinterface

interface exps_out_if import exps_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     moved;
  logic [POSITION_W-1:0]    new_position;
  logic signed [DISP_W-1:0] particle_displacement;
  logic signed [DSUM_W-1:0] displacement_sum;
  logic [SQSUM_W-1:0]       squared_sum;

  modport source (output valid, moved, new_position, particle_displacement,
                  displacement_sum, squared_sum, input ready);
  modport sink (input valid, moved, new_position, particle_displacement,
                displacement_sum, squared_sum, output ready);
endinterface

// ----- design/exps_ram.sv -----
// exps_ram: generic single-write, single-read memory with registered read
// no dependencies
`timescale 1ns / 1ps

module exps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/exps_div.sv -----
// exps_div: restoring divider, one quotient bit per cycle
// no dependencies
`timescale 1ns / 1ps

module exps_div #(
  parameter int unsigned W = 11
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(W + 1);

  logic          busy_q, busy_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W:0]    rem_q, rem_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  dvs_q, dvs_d;
  logic [W:0]    shifted;
  logic [W:0]    diff;

  assign shifted = {rem_q[W-1:0], quo_q[W-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(W);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
        if (!diff[W]) begin
          rem_d = diff;
          quo_d = {quo_q[W-2:0], 1'b1};
        end else begin
          rem_d = shifted;
          quo_d = {quo_q[W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = busy_q && (cnt_q == '0);
  assign quotient_o = quo_q;

endmodule

// ----- design/exclusion_process_ring_step.sv -----
// exclusion_process_ring_step: exclusion-process lattice gas on a ring
// depends on exps_pkg, exps_if (exps_in_if, exps_out_if), exps_ram, exps_div
`timescale 1ns / 1ps

//  channel   dir  beat contents                                   handshake
//  in_i      in   kind, particle, random_fraction                 valid/ready
//  out_o     out  moved, new_position, particle_displacement,     valid/ready
//                 displacement_sum, squared_sum
//  cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i                 write only
//
//  a move result is loaded at the write-back, after the particle read at the accepting
//  edge and the occupancy read; the next move is taken only after the write-back
//  an initialize runs the divider, a sweep over all MAX_SITES sites, a read and a
//  write per particle entry not placed by the sweep, one closing check and the emit
//  after reset a clearing pass (sweep over all sites, read and write-back per particle
//  entry) zeroes occupancy and displacements; in_i is held off meanwhile
//  a result waiting on out_o holds the next write-back or emit

module exclusion_process_ring_step import exps_pkg::*; #(
  parameter int unsigned MAX_SITES     = DEF_MAX_SITES,
  parameter int unsigned MAX_PARTICLES = DEF_MAX_PARTICLES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  exps_in_if.sink               in_i,
  exps_out_if.source            out_o
);

  // site count width, site index width, particle count/index widths
  localparam int unsigned SW  = $clog2(MAX_SITES + 1);
  localparam int unsigned SIW = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
  localparam int unsigned PW  = $clog2(MAX_PARTICLES + 1);
  localparam int unsigned PIW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  // particle word: {displacement, site}
  localparam int unsigned PWW = DISP_W + SIW;

  exps_state_e state_q, state_d;

  // configuration
  logic [SITE_COUNT_W-1:0]     sc_q;
  logic [PARTICLE_COUNT_W-1:0] pc_q;
  logic [RIGHT_PROB_W-1:0]     rp_q;

  // effective sizes
  logic [SW-1:0] s_eff;
  logic [PW-1:0] n_eff;
  logic          low_dens;

  // initialize / clearing pass
  logic           init_q, init_d;
  logic [SIW-1:0] i_q, i_d;
  logic [SW-1:0]  ph_q, ph_d;
  logic [SW-1:0]  step_q, step_d;
  logic [PW-1:0]  placed_q, placed_d;
  logic           placing, take;

  // move pipeline
  logic                     right_q, right_d;
  logic [SIW-1:0]           pos_q, pos_d;
  logic [SIW-1:0]           next_q, next_d;
  logic signed [DISP_W-1:0] hops_q, hops_d;
  logic [PIW-1:0]           p_q, p_d;
  logic                     pend_q, pend_d;
  logic [SIW-1:0]           pend_addr_q, pend_addr_d;

  // running sums
  logic signed [DSUM_W-1:0] dsum_q, dsum_d;
  logic [SQSUM_W-1:0]       sqsum_q, sqsum_d;

  // output register
  logic                     ovld_q, ovld_d;
  logic                     omoved_q, omoved_d;
  logic [POSITION_W-1:0]    opos_q, opos_d;
  logic signed [DISP_W-1:0] odisp_q, odisp_d;
  logic                     out_free;

  // handshake decode
  logic in_acc, acc_init, acc_move, p_ok;

  // memory ports
  logic           pm_we, pm_re;
  logic [PIW-1:0] pm_waddr, pm_raddr;
  logic [PWW-1:0] pm_wdata, pm_rdata;
  logic           om_we, om_re;
  logic [SIW-1:0] om_waddr, om_raddr;
  logic           om_wdata, om_rdata;

  // divider
  logic          div_start, div_done;
  logic [SW-1:0] div_divisor, div_quo;

  // move evaluation from the particle word
  logic [SIW-1:0]           rd_pos, mv_pos, mv_next;
  logic signed [DISP_W-1:0] rd_hops;

  // write-back evaluation
  logic                     blocked, sat;
  logic signed [DISP_W-1:0] newd;
  logic signed [DISP_W:0]   dbl;
  logic [SQSUM_W-1:0]       dbl_x;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_q <= SITE_COUNT_RST;
      pc_q <= PARTICLE_COUNT_RST;
      rp_q <= RIGHT_PROB_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SITE_COUNT:     sc_q <= cfg_data_i[SITE_COUNT_W-1:0];
        REG_PARTICLE_COUNT: pc_q <= cfg_data_i[PARTICLE_COUNT_W-1:0];
        REG_RIGHT_PROB:     rp_q <= cfg_data_i[RIGHT_PROB_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp ring length to [2, MAX_SITES], particles to [1, min(MAX_PARTICLES, s-1)]
  always_comb begin
    logic [31:0] s32;
    logic [31:0] n32;
    s32 = 32'(sc_q);
    if (s32 < 32'd2) s32 = 32'd2;
    if (s32 > 32'(MAX_SITES)) s32 = 32'(MAX_SITES);
    n32 = 32'(pc_q);
    if (n32 > 32'(MAX_PARTICLES)) n32 = 32'(MAX_PARTICLES);
    if (n32 > s32 - 32'd1) n32 = s32 - 32'd1;
    if (n32 < 32'd1) n32 = 32'd1;
    s_eff    = SW'(s32);
    n_eff    = PW'(n32);
    low_dens = (n32 << 1) <= s32;
  end

  // ------------------------------------------------------------- handshake
  assign out_free = !ovld_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc   = in_i.valid && in_i.ready;
  assign acc_init = in_acc && (in_i.kind == KIND_INIT);
  assign p_ok     = 32'(in_i.particle) < 32'(n_eff);
  assign acc_move = in_acc && (in_i.kind == KIND_MOVE) && p_ok;

  // ------------------------------------------------------- placement divider
  // low density: step = S/N; high density: step = S/(S-N)
  assign div_start   = acc_init;
  assign div_divisor = low_dens ? SW'(n_eff) : (s_eff - SW'(n_eff));

  exps_div #(.W(SW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (s_eff),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // sweep: ph_q tracks i mod step
  assign placing = init_q && (SW'(i_q) < s_eff) && (placed_q < n_eff);
  assign take    = low_dens ? (ph_q == '0) : (ph_q != (step_q >> 1));

  // ------------------------------------------------------ move evaluation
  assign rd_pos  = pm_rdata[SIW-1:0];
  assign rd_hops = pm_rdata[PWW-1 -: DISP_W];

  always_comb begin
    mv_pos = (32'(rd_pos) >= 32'(MAX_SITES)) ? '0 : rd_pos;
    if (right_q) begin
      mv_next = (32'(mv_pos) + 32'd1 >= 32'(s_eff)) ? '0 : SIW'(mv_pos + 1'b1);
    end else begin
      mv_next = (mv_pos == '0) ? SIW'(s_eff - 1'b1) : SIW'(mv_pos - 1'b1);
    end
  end

  // write-back: square changes by 2d+1 on a right hop, 1-2d on a left hop
  assign blocked = om_rdata;
  assign sat     = right_q ? (hops_q >= DISP_LIMIT) : (hops_q <= DISP_LIMIT_NEG);
  assign newd    = (blocked || sat) ? hops_q : (right_q ? hops_q + 1'b1 : hops_q - 1'b1);
  assign dbl     = {hops_q, 1'b0};
  assign dbl_x   = SQSUM_W'(dbl);

  // ------------------------------------------------------------ next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc_init) begin
          state_d = ST_DIV;
        end else if (acc_move) begin
          state_d = ST_MV_A;
        end else if (in_acc) begin
          state_d = ST_EMIT;
        end
      end
      ST_DIV: begin
        if (div_done) state_d = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (i_q == SIW'(MAX_SITES - 1)) state_d = ST_TAIL_RD;
      end
      ST_TAIL_RD: begin
        if (placed_q == PW'(MAX_PARTICLES)) begin
          state_d = init_q ? ST_EMIT : ST_IDLE;
        end else begin
          state_d = ST_TAIL_WR;
        end
      end
      ST_TAIL_WR: state_d = ST_TAIL_RD;
      ST_MV_A:    state_d = ST_MV_B;
      ST_MV_B: begin
        if (out_free) state_d = ST_IDLE;
      end
      ST_EMIT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------- memory control
  always_comb begin
    pm_we    = 1'b0;
    pm_waddr = '0;
    pm_wdata = '0;
    pm_re    = 1'b0;
    pm_raddr = '0;
    om_we    = 1'b0;
    om_waddr = '0;
    om_wdata = 1'b0;
    om_re    = 1'b0;
    om_raddr = '0;
    unique case (state_q)
      ST_IDLE: begin
        pm_re    = acc_move;
        pm_raddr = PIW'(in_i.particle);
      end
      ST_SWEEP: begin
        om_we    = 1'b1;
        om_waddr = i_q;
        om_wdata = placing && take;
        pm_we    = placing && take;
        pm_waddr = PIW'(placed_q);
        pm_wdata = {{DISP_W{1'b0}}, i_q};
      end
      ST_TAIL_RD: begin
        pm_re    = (placed_q != PW'(MAX_PARTICLES));
        pm_raddr = PIW'(placed_q);
      end
      ST_TAIL_WR: begin
        // on an initialize unplaced particles go to site 0; other entries keep their site
        pm_we    = 1'b1;
        pm_waddr = PIW'(placed_q);
        pm_wdata = {{DISP_W{1'b0}},
                    (init_q && (placed_q < n_eff)) ? {SIW{1'b0}} : rd_pos};
      end
      ST_MV_A: begin
        om_re    = 1'b1;
        om_raddr = mv_next;
      end
      ST_MV_B: begin
        pm_we    = out_free && !blocked;
        pm_waddr = p_q;
        pm_wdata = {newd, next_q};
        om_we    = out_free;
        om_waddr = pos_q;
        om_wdata = blocked;
      end
      default: ;
    endcase
    // target site marked in the cycle after write-back
    if (pend_q) begin
      om_we    = 1'b1;
      om_waddr = pend_addr_q;
      om_wdata = 1'b1;
    end
  end

  exps_ram #(.WIDTH(PWW), .DEPTH(MAX_PARTICLES)) u_pmem (
    .clk_i   (clk_i),
    .we_i    (pm_we),
    .waddr_i (pm_waddr),
    .wdata_i (pm_wdata),
    .re_i    (pm_re),
    .raddr_i (pm_raddr),
    .rdata_o (pm_rdata)
  );

  exps_ram #(.WIDTH(1), .DEPTH(MAX_SITES)) u_omem (
    .clk_i   (clk_i),
    .we_i    (om_we),
    .waddr_i (om_waddr),
    .wdata_i (om_wdata),
    .re_i    (om_re),
    .raddr_i (om_raddr),
    .rdata_o (om_rdata)
  );

  // ------------------------------------------------------- register update
  always_comb begin
    init_d      = init_q;
    i_d         = i_q;
    ph_d        = ph_q;
    step_d      = step_q;
    placed_d    = placed_q;
    right_d     = right_q;
    pos_d       = pos_q;
    next_d      = next_q;
    hops_d      = hops_q;
    p_d         = p_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    dsum_d      = dsum_q;
    sqsum_d     = sqsum_q;
    ovld_d      = ovld_q && !out_o.ready;
    omoved_d    = omoved_q;
    opos_d      = opos_q;
    odisp_d     = odisp_q;
    unique case (state_q)
      ST_IDLE: begin
        p_d     = PIW'(in_i.particle);
        right_d = {1'b0, in_i.random_fraction} < rp_q;
        if (acc_init) begin
          init_d = 1'b1;
        end
      end
      ST_DIV: begin
        step_d   = (div_quo == '0) ? SW'(1) : div_quo;
        i_d      = '0;
        ph_d     = '0;
        placed_d = '0;
      end
      ST_SWEEP: begin
        i_d  = i_q + 1'b1;
        ph_d = (ph_q + 1'b1 == step_q) ? '0 : SW'(ph_q + 1'b1);
        if (placing && take) placed_d = placed_q + 1'b1;
      end
      ST_TAIL_WR: placed_d = placed_q + 1'b1;
      ST_MV_A: begin
        pos_d  = mv_pos;
        next_d = mv_next;
        hops_d = rd_hops;
      end
      ST_MV_B: begin
        if (out_free) begin
          pend_d      = 1'b1;
          pend_addr_d = next_q;
          if (!blocked && !sat) begin
            if (right_q) begin
              dsum_d  = dsum_q + 1'b1;
              sqsum_d = sqsum_q + dbl_x + SQSUM_W'(1);
            end else begin
              dsum_d  = dsum_q - 1'b1;
              sqsum_d = sqsum_q - dbl_x + SQSUM_W'(1);
            end
          end
          ovld_d   = 1'b1;
          omoved_d = !blocked;
          opos_d   = POSITION_W'(blocked ? pos_q : next_q);
          odisp_d  = newd;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          // sums drop to zero with the initialize beat, not while an older beat waits
          if (init_q) begin
            dsum_d  = '0;
            sqsum_d = '0;
          end
          init_d   = 1'b0;
          ovld_d   = 1'b1;
          omoved_d = 1'b0;
          opos_d   = '0;
          odisp_d  = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_SWEEP;     // clearing pass
      init_q   <= 1'b0;
      i_q      <= '0;
      ph_q     <= '0;
      step_q   <= SW'(1);
      placed_q <= '0;
      pend_q   <= 1'b0;
      dsum_q   <= '0;
      sqsum_q  <= '0;
      ovld_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      init_q   <= init_d;
      i_q      <= i_d;
      ph_q     <= ph_d;
      step_q   <= step_d;
      placed_q <= placed_d;
      pend_q   <= pend_d;
      dsum_q   <= dsum_d;
      sqsum_q  <= sqsum_d;
      ovld_q   <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    right_q     <= right_d;
    pos_q       <= pos_d;
    next_q      <= next_d;
    hops_q      <= hops_d;
    p_q         <= p_d;
    pend_addr_q <= pend_addr_d;
    omoved_q    <= omoved_d;
    opos_q      <= opos_d;
    odisp_q     <= odisp_d;
  end

  // ------------------------------------------------------------------ out
  assign out_o.valid                 = ovld_q;
  assign out_o.moved                 = omoved_q;
  assign out_o.new_position          = opos_q;
  assign out_o.particle_displacement = odisp_q;
  assign out_o.displacement_sum      = dsum_q;
  assign out_o.squared_sum           = sqsum_q;

endmodule

// ----- design/exps_checker.sv -----
// exps_checker: port-level assertions for exclusion_process_ring_step
// depends on exps_pkg; bound to the top level below
`timescale 1ns / 1ps

module exps_checker import exps_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_i,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic                     moved_i,
  input logic [POSITION_W-1:0]    new_position_i,
  input logic signed [DISP_W-1:0] particle_displacement_i,
  input logic signed [DSUM_W-1:0] displacement_sum_i,
  input logic [SQSUM_W-1:0]       squared_sum_i
);

  logic       in_acc, out_acc;
  logic [1:0] pend_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // items accepted and not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(moved_i)
      && $stable(new_position_i) && $stable(particle_displacement_i)
      && $stable(displacement_sum_i) && $stable(squared_sum_i))
    else $error("result beat changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("input taken twice in a row");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !$past(out_valid_i && !out_ready_i) |-> pend_q != 2'd0)
    else $error("result beat without an accepted item");

  a_ready_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i |-> pend_q <= 2'd1)
    else $error("ready with more than one result owed");

endmodule

bind exclusion_process_ring_step exps_checker u_exps_checker (
  .clk_i                   (clk_i),
  .rst_ni                  (rst_ni),
  .in_valid_i              (in_i.valid),
  .in_ready_i              (in_i.ready),
  .out_valid_i             (out_o.valid),
  .out_ready_i             (out_o.ready),
  .moved_i                 (out_o.moved),
  .new_position_i          (out_o.new_position),
  .particle_displacement_i (out_o.particle_displacement),
  .displacement_sum_i      (out_o.displacement_sum),
  .squared_sum_i           (out_o.squared_sum)
);
